>>> sv/sha224_message_hash_unit_defines.svh
// Assertion macros for the SHA-224 hash unit.
`ifndef SHA224_MESSAGE_HASH_UNIT_DEFINES_SVH
`define SHA224_MESSAGE_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHA224_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SHA224_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sha224_pkg.sv
// Types, constants and round functions for the SHA-224 hash unit.
`timescale 1ns / 1ps

package sha224_pkg;

  localparam int unsigned BlkDepth  = 16;
  localparam int unsigned HashDepth = 8;
  localparam int unsigned BlkAw     = $clog2(BlkDepth);
  localparam int unsigned HashAw    = $clog2(HashDepth);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_HLOAD,
    ST_ROUND,
    ST_HSTORE,
    ST_ORD,
    ST_OWAIT
  } state_e;

  localparam logic [31:0] IV [HashDepth] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> sv/sha224_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module sha224_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sha224_message_hash_unit.sv
// SHA-224 hash unit: byte items in, seven digest words out.
`timescale 1ns / 1ps
`include "sha224_message_hash_unit_defines.svh"

// A byte item is taken while the unit is idle. The 64-byte block and the eight hash
// words sit in two small RAMs; one round unit runs the compression. When an
// item fills a block, the unit loads the hash words, runs the round steps,
// then adds and writes the words back before taking the next item.
// A closing item adds a padding pass and one compression, or two of each
// when 56 or more bytes sit in the final block, then the unit hands out
// the seven digest words through a one-entry output register.
// The unit then starts a new message from the SHA-224 initial values.

module sha224_message_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  import sha224_pkg::*;

  state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic        fresh_q, fresh_d;
  logic        pend_last_q, pend_last_d;
  logic        pad_active_q, pad_active_d;
  logic        second_q, second_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] acc_q, acc_d;
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] wk_q, wk_d;
  logic [HashAw-1:0] hrd_addr_q, hrd_addr_d;
  logic [31:0] digest_q, digest_d;
  logic [2:0]  index_q, index_d;
  logic        lastw_q, lastw_d;

  logic              blk_we, blk_re;
  logic [BlkAw-1:0]  blk_waddr, blk_raddr;
  logic [31:0]       blk_wdata, blk_rdata;
  logic              hash_we, hash_re;
  logic [HashAw-1:0] hash_waddr, hash_raddr;
  logic [31:0]       hash_wdata, hash_rdata;

  logic [5:0]  fill;
  logic [1:0]  lane;
  logic [3:0]  wi;
  logic [3:0]  pidx;
  logic [31:0] acc_ins, pad_word, len_word, w_new, sched, hash_rd;
  logic [31:0] t1, t2, ch, maj;
  logic [63:0] bits;
  logic        need_second, out_free;

  sha224_ram #(.Width(32), .Depth(BlkDepth)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .re_i    (blk_re),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  sha224_ram #(.Width(32), .Depth(HashDepth)) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (hash_we),
    .waddr_i (hash_waddr),
    .wdata_i (hash_wdata),
    .re_i    (hash_re),
    .raddr_i (hash_raddr),
    .rdata_o (hash_rdata)
  );

  // Hash RAM contents count as the initial values until the first write-back.
  assign hash_rd = fresh_q ? IV[hrd_addr_q] : hash_rdata;

  assign fill        = len_q[5:0];
  assign lane        = fill[1:0];
  assign wi          = fill[5:2];
  assign pidx        = cnt_q[3:0];
  assign bits        = {len_q[60:0], 3'b000};
  assign need_second = (fill[5:3] == 3'b111);
  assign len_word    = (pidx == 4'd14) ? bits[63:32] : bits[31:0];
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    acc_ins = acc_q;
    pad_word = 32'h0;
    case (lane)
      2'd0: begin
        acc_ins[31:24] = data_byte_i;
        pad_word = {8'h80, 24'h0};
      end
      2'd1: begin
        acc_ins[23:16] = data_byte_i;
        pad_word = {acc_q[31:24], 8'h80, 16'h0};
      end
      2'd2: begin
        acc_ins[15:8] = data_byte_i;
        pad_word = {acc_q[31:16], 8'h80, 8'h0};
      end
      default: begin
        acc_ins[7:0] = data_byte_i;
        pad_word = {acc_q[31:8], 8'h80};
      end
    endcase
  end

  assign sched = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  assign w_new = (cnt_q < 7'd16) ? blk_rdata : sched;
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + big_sigma1(v_q[4]) + ch + wk_q;
  assign t2    = big_sigma0(v_q[0]) + maj;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    len_d        = len_q;
    fresh_d      = fresh_q;
    pend_last_d  = pend_last_q;
    pad_active_d = pad_active_q;
    second_d     = second_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    acc_d        = acc_q;
    v_d          = v_q;
    w_d          = w_q;
    wk_d         = wk_q;
    digest_d     = digest_q;
    index_d      = index_q;
    lastw_d      = lastw_q;
    blk_we       = 1'b0;
    blk_waddr    = wi;
    blk_wdata    = acc_ins;
    blk_re       = 1'b0;
    blk_raddr    = '0;
    hash_we      = 1'b0;
    hash_waddr   = HashAw'(cnt_q[2:0] - 3'd1);
    hash_wdata   = hash_rd + v_q[0];
    hash_re      = 1'b0;
    hash_raddr   = cnt_q[2:0];
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_present_i) begin
            acc_d = acc_ins;
            len_d = len_q + 64'd1;
            blk_we = (lane == 2'd3);
          end
          if (byte_present_i && fill == 6'd63) begin
            pend_last_d = last_byte_i;
            cnt_d = '0;
            state_d = ST_HLOAD;
          end else if (last_byte_i) begin
            pad_active_d = 1'b1;
            second_d = 1'b0;
            cnt_d = '0;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // skip words already holding message bytes on the first pass
        blk_we = second_q || (pidx >= wi);
        blk_waddr = pidx;
        if (second_q) begin
          blk_wdata = (pidx < 4'd14) ? 32'h0 : len_word;
        end else if (pidx == wi) begin
          blk_wdata = pad_word;
        end else if (pidx < 4'd14 || need_second) begin
          blk_wdata = 32'h0;
        end else begin
          blk_wdata = len_word;
        end
        cnt_d = cnt_q + 7'd1;
        if (pidx == 4'd15) begin
          cnt_d = '0;
          state_d = ST_HLOAD;
        end
      end
      ST_HLOAD: begin
        hash_re = (cnt_q < 7'd8);
        if (cnt_q != 7'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
          v_d[7] = hash_rd;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          blk_re = 1'b1;
          blk_raddr = '0;
          cnt_d = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (cnt_q < 7'd64) begin
          for (int i = 0; i < 15; i++) begin
            w_d[i] = w_q[i+1];
          end
          w_d[15] = w_new;
          wk_d = w_new + K[cnt_q[5:0]];
        end
        if (cnt_q < 7'd15) begin
          blk_re = 1'b1;
          blk_raddr = BlkAw'(cnt_q[3:0] + 4'd1);
        end
        if (cnt_q != 7'd0) begin
          v_d[0] = t1 + t2;
          v_d[1] = v_q[0];
          v_d[2] = v_q[1];
          v_d[3] = v_q[2];
          v_d[4] = v_q[3] + t1;
          v_d[5] = v_q[4];
          v_d[6] = v_q[5];
          v_d[7] = v_q[6];
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          cnt_d = '0;
          state_d = ST_HSTORE;
        end
      end
      ST_HSTORE: begin
        hash_re = (cnt_q < 7'd8);
        if (cnt_q != 7'd0) begin
          hash_we = 1'b1;
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i+1];
          end
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          fresh_d = 1'b0;
          cnt_d = '0;
          if (pad_active_q) begin
            if (need_second && !second_q) begin
              second_d = 1'b1;
              state_d = ST_PAD;
            end else begin
              pad_active_d = 1'b0;
              second_d = 1'b0;
              state_d = ST_ORD;
            end
          end else if (pend_last_q) begin
            pend_last_d = 1'b0;
            pad_active_d = 1'b1;
            second_d = 1'b0;
            state_d = ST_PAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ORD: begin
        hash_re = 1'b1;
        state_d = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          digest_d = hash_rd;
          index_d = cnt_q[2:0];
          lastw_d = (cnt_q[2:0] == 3'd6);
          if (cnt_q[2:0] == 3'd6) begin
            fresh_d = 1'b1;
            len_d = '0;
            cnt_d = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 7'd1;
            state_d = ST_ORD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign hrd_addr_d = hash_re ? hash_raddr : hrd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      len_q        <= '0;
      fresh_q      <= 1'b1;
      pend_last_q  <= 1'b0;
      pad_active_q <= 1'b0;
      second_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      len_q        <= len_d;
      fresh_q      <= fresh_d;
      pend_last_q  <= pend_last_d;
      pad_active_q <= pad_active_d;
      second_q     <= second_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    v_q        <= v_d;
    w_q        <= w_d;
    wk_q       <= wk_d;
    hrd_addr_q <= hrd_addr_d;
    digest_q   <= digest_d;
    index_q    <= index_d;
    lastw_q    <= lastw_d;
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_q;
  assign word_index_o  = index_q;
  assign last_word_o   = lastw_q;

  `SHA224_ASSERT_IMP(a_no_blk_write_in_rounds, state_q == ST_ROUND, !blk_we, "block write during rounds")
  `SHA224_ASSERT_IMP(a_hash_write_only_store, hash_we, state_q == ST_HSTORE, "stray hash write")
  `SHA224_ASSERT_NXT(a_fresh_clear_after_store, fresh_q && state_q == ST_HSTORE && cnt_q == 7'd8, !fresh_q, "initial values still in use")

endmodule
